### src/bdp_pkg.sv
// bdp_pkg: shared types and field widths of the binomial derivative product core
// used by binomial_derivative_product_core, bdp_checker and the testbench, no dependencies
package bdp_pkg;

	localparam int DEGREE_W   = 5;
	localparam int COEF_W     = 33;
	localparam int POWER_W    = 5;
	localparam int BINO_W     = 14;
	localparam int DERIV_W    = 18;
	localparam int PROD_W     = BINO_W + DERIV_W;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 40;
	localparam int M_PAD_W    = M_TDATA_W - COEF_W - POWER_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BINO,
		ST_DERIV,
		ST_CSET,
		ST_CMUL,
		ST_CACC,
		ST_EMIT
	} bdp_state_t;

endpackage

### src/binomial_derivative_product_core.sv
// binomial_derivative_product_core: builds row n of pascal's triangle, its derivative row,
// and streams the 2n coefficients of their convolution; depends on bdp_pkg
//
// channel   dir   fields (tdata low bit up)                       transfer when
// s_axis    in    tdata: degree[4:0], pad[7:5]                     tvalid & tready
// m_axis    out   tdata: coefficient[32:0], power_index[37:33],    tvalid & tready
//                 pad[39:38]; tlast: last
//
// one request at a time; s_axis_tready is high only while idle
// the convolution loop runs on the single 14x18 multiplier and one accumulator adder
// degree 0 or above MAX_DEGREE is accepted and dropped with no results
// a stalled m_axis holds the sequencer in place; reset clears control only
module binomial_derivative_product_core
	import bdp_pkg::*;
#(
	parameter int MAX_DEGREE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,   // degree[4:0], zero pad
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // coefficient[32:0], power_index[37:33], pad
	output logic                 m_axis_tlast
);

	localparam int ROW_LEN = MAX_DEGREE + 1;
	localparam int IW      = $clog2(ROW_LEN);
	localparam int CW      = IW + 1;
	localparam logic [DEGREE_W-1:0] MAX_DEG_V = DEGREE_W'(MAX_DEGREE);

	bdp_state_t state_q, state_d;

	logic [IW-1:0]      n_q, r_q, j_q, i_q;
	logic [CW-1:0]      k_q;
	logic [BINO_W-1:0]  prev_q;
	logic [COEF_W-1:0]  acc_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COEF_W-1:0]  coef_q;
	logic [BINO_W-1:0]  bino_q  [ROW_LEN];
	logic [DERIV_W-1:0] deriv_q [ROW_LEN];

	logic [DEGREE_W-1:0]   deg;
	logic                  deg_ok;
	logic                  in_xfer, out_xfer;
	logic [BINO_W-1:0]     bino_rd, bino_sum;
	logic [IW-1:0]         j_inc;
	logic [IW+BINO_W-1:0]  dmul;
	logic [CW-1:0]         n_ext, i_ext, lo, hi, dix;
	logic                  at_hi, k_last, row_end;
	logic [PROD_W-1:0]     conv_mul;
	logic [COEF_W-1:0]     acc_sum;

	assign deg      = s_axis_tdata[DEGREE_W-1:0];
	assign deg_ok   = (deg != '0) && (deg <= MAX_DEG_V);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// pascal row update, ascending with the old left neighbor held in prev_q
	assign bino_rd  = (j_q == r_q) ? '0 : bino_q[j_q];
	assign bino_sum = bino_rd + prev_q;
	assign row_end  = (j_q == r_q);

	assign j_inc = j_q + 1'b1;
	assign dmul  = (IW+BINO_W)'(j_inc) * (IW+BINO_W)'(bino_q[j_inc]);

	// convolution index bounds for power k
	assign n_ext    = CW'(n_q);
	assign i_ext    = CW'(i_q);
	assign lo       = (k_q > n_ext) ? (k_q - n_ext) : '0;
	assign hi       = (k_q < n_ext) ? k_q : n_ext;
	assign at_hi    = (i_ext == hi);
	assign dix      = k_q - i_ext;
	assign conv_mul = PROD_W'(bino_q[i_q]) * PROD_W'(deriv_q[dix[IW-1:0]]);
	assign acc_sum  = acc_q + COEF_W'(prod_q);
	assign k_last   = ((k_q + 1'b1) == {n_q, 1'b0});

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && deg_ok)
					state_d = ST_BINO;
			end
			ST_BINO: begin
				if (row_end && (r_q == n_q))
					state_d = ST_DERIV;
			end
			ST_DERIV: begin
				if (j_q == n_q)
					state_d = ST_CSET;
			end
			ST_CSET: state_d = ST_CMUL;
			ST_CMUL: state_d = ST_CACC;
			ST_CACC: begin
				if (at_hi)
					state_d = ST_EMIT;
				else
					state_d = ST_CMUL;
			end
			ST_EMIT: begin
				if (m_axis_tready)
					state_d = k_last ? ST_IDLE : ST_CSET;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_EMIT: m_axis_tvalid = 1'b1;
			default: begin
				s_axis_tready = 1'b0;
				m_axis_tvalid = 1'b0;
			end
		endcase
	end

	assign m_axis_tdata = {{M_PAD_W{1'b0}}, POWER_W'(k_q), coef_q};
	assign m_axis_tlast = k_last;

	// control and sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			r_q     <= '0;
			j_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
			prev_q  <= '0;
			acc_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && deg_ok) begin
						n_q    <= deg[IW-1:0];
						r_q    <= IW'(1);
						j_q    <= IW'(1);
						prev_q <= BINO_W'(1);
					end
				end
				ST_BINO: begin
					if (row_end) begin
						if (r_q == n_q) begin
							j_q <= '0;
						end else begin
							r_q    <= r_q + 1'b1;
							j_q    <= IW'(1);
							prev_q <= BINO_W'(1);
						end
					end else begin
						j_q    <= j_inc;
						prev_q <= bino_rd;
					end
				end
				ST_DERIV: begin
					if (j_q == n_q)
						k_q <= '0;
					else
						j_q <= j_inc;
				end
				ST_CSET: begin
					i_q   <= lo[IW-1:0];
					acc_q <= '0;
				end
				ST_CACC: begin
					acc_q <= acc_sum;
					if (!at_hi)
						i_q <= i_q + 1'b1;
				end
				ST_EMIT: begin
					if (m_axis_tready && !k_last)
						k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// coefficient rows and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && deg_ok)
					bino_q[0] <= BINO_W'(1);
			end
			ST_BINO: bino_q[j_q] <= bino_sum;
			ST_DERIV: begin
				if (j_q == n_q)
					deriv_q[j_q] <= '0;
				else
					deriv_q[j_q] <= DERIV_W'(dmul);
			end
			ST_CMUL: prod_q <= conv_mul;
			ST_CACC: begin
				if (at_hi)
					coef_q <= acc_sum;
			end
			default: ;
		endcase
	end

endmodule

### src/bdp_checker.sv
// bdp_checker: port-level assertions for binomial_derivative_product_core
// depends on bdp_pkg; bound to binomial_derivative_product_core at the end of this file
module bdp_checker
	import bdp_pkg::*;
#(
	parameter int MAX_DEGREE = 16
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic [S_TDATA_W-1:0] s_axis_tdata,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata,
	input logic                 m_axis_tlast
);

	localparam logic [DEGREE_W-1:0] MAX_DEG_V = DEGREE_W'(MAX_DEGREE);

	logic [DEGREE_W-1:0] deg;
	assign deg = s_axis_tdata[DEGREE_W-1:0];

	// never takes a request while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input ready while output valid");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
		else $error("stalled output changed");

	// last result lands on an odd power
	a_last_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[COEF_W])
		else $error("last result on even power");

	// ready again right after the last transfer
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("not idle after last transfer");

	// out-of-range degree is dropped at once
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && ((deg == '0) || (deg > MAX_DEG_V)))
		|=> (s_axis_tready && !m_axis_tvalid))
		else $error("dropped request started work");

endmodule

bind binomial_derivative_product_core bdp_checker #(.MAX_DEGREE(MAX_DEGREE)) u_bdp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

### sim/tb_binomial_derivative_product_core.sv
`timescale 1ns / 100ps
// tb_binomial_derivative_product_core: stream test of the binomial derivative product core,
// a short table of degrees with some coefficients typed in, then random bursts checked against
// a behavioral predictor; depends on bdp_pkg and binomial_derivative_product_core
module tb_binomial_derivative_product_core;
	import bdp_pkg::*;

	localparam int MAX_DEGREE   = 16;
	localparam int ROW_LEN      = MAX_DEGREE + 1;
	localparam int RANDOM_ITEMS = 186;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 1000;
	localparam int TABLE_ROWS   = 24;

	typedef struct packed {
		logic [COEF_W-1:0]  coefficient;
		logic [POWER_W-1:0] power_index;
		logic               last;
	} product_term_t;

	typedef struct packed {
		logic [DEGREE_W-1:0]    degree;
		logic [POWER_W-1:0]     known_from;
		logic [2:0]             known_count;
		logic [0:3][COEF_W-1:0] known;
	} directed_row_t;

	typedef enum int {
		SINK_OPEN,
		SINK_CHOPPY,
		SINK_STARVED
	} sink_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;   // degree[4:0], zero pad
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;   // coefficient[32:0], power_index[37:33], pad
	logic                 m_axis_tlast;

	logic [BINO_W-1:0]  pascal_row [ROW_LEN];
	logic [DERIV_W-1:0] slope_row [ROW_LEN];
	logic [COEF_W-1:0]  last_sum;
	product_term_t      pending_terms [$];
	int                 fail_count = 0;
	int                 quiet_cycles = 0;
	int                 sink_phase_left = 0;
	sink_mode_t         sink_mode = SINK_OPEN;

	// degree 1 gives 1 + x, degree 2 gives 2 + 6x + 6x^2 + 2x^3,
	// degree 16 gives 16*C(31,k): 16 and 496 at both ends, 4808643120 in the middle
	directed_row_t directed_rows [TABLE_ROWS] = '{
		'{5'd1,  5'd0,  3'd2, '{33'd1, 33'd1, 33'd0, 33'd0}},
		'{5'd2,  5'd0,  3'd4, '{33'd2, 33'd6, 33'd6, 33'd2}},
		'{5'd0,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd16, 5'd0,  3'd2, '{33'd16, 33'd496, 33'd0, 33'd0}},
		'{5'd17, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd16, 5'd15, 3'd2, '{33'd4808643120, 33'd4808643120, 33'd0, 33'd0}},
		'{5'd31, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd16, 5'd30, 3'd2, '{33'd496, 33'd16, 33'd0, 33'd0}},
		'{5'd3,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd4,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd5,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd6,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd7,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd8,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd9,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd10, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd11, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd12, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd13, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd14, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd15, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd0,  5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd24, 5'd0,  3'd0, '{33'd0, 33'd0, 33'd0, 33'd0}},
		'{5'd1,  5'd0,  3'd2, '{33'd1, 33'd1, 33'd0, 33'd0}}
	};

	binomial_derivative_product_core #(
		.MAX_DEGREE(MAX_DEGREE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// pascal row, slope row, then the convolution of the two
	task automatic predict_product(input logic [DEGREE_W-1:0] degree);
		int            n;
		int            r;
		int            j;
		int            k;
		int            i;
		int            lo;
		int            hi;
		logic [63:0]   acc;
		product_term_t term;
		n = degree;
		if (n == 0 || n > MAX_DEGREE)
			return;
		pascal_row[0] = 1;
		for (r = 1; r <= n; r++) begin
			pascal_row[r] = 1;
			for (j = r - 1; j >= 1; j--)
				pascal_row[j] = pascal_row[j] + pascal_row[j - 1];
		end
		for (j = 0; j < n; j++)
			slope_row[j] = DERIV_W'((j + 1) * int'(pascal_row[j + 1]));
		slope_row[n] = '0;
		for (k = 0; k < 2 * n; k++) begin
			acc = '0;
			lo = (k > n) ? k - n : 0;
			hi = (k < n) ? k : n;
			for (i = lo; i <= hi; i++)
				acc += 64'(pascal_row[i]) * 64'(slope_row[k - i]);
			last_sum = acc[COEF_W-1:0];
			term.coefficient = last_sum;
			term.power_index = POWER_W'(k);
			term.last = (k == 2 * n - 1);
			pending_terms.push_back(term);
		end
	endtask

	// holds tvalid high; the caller lowers it only when a gap follows
	task automatic send_degree(input logic [DEGREE_W-1:0] degree);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(S_TDATA_W-DEGREE_W){1'b0}}, degree};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_product(degree);
	endtask

	initial begin
		int                  row;
		int                  idx;
		int                  slot;
		int                  gap;
		int                  burst;
		int                  pick;
		int                  valid_sent;
		logic [DEGREE_W-1:0] degree;
		product_term_t       term;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		valid_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (row = 0; row < TABLE_ROWS; row++) begin
			send_degree(directed_rows[row].degree);
			for (idx = 0; idx < int'(directed_rows[row].known_count); idx++) begin
				slot = pending_terms.size() - 2 * int'(directed_rows[row].degree)
					+ int'(directed_rows[row].known_from) + idx;
				term = pending_terms[slot];
				term.coefficient = directed_rows[row].known[idx];
				pending_terms[slot] = term;
			end
			gap = $urandom_range(0, 3);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		// let the directed part drain completely
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0)
			@(posedge clk);

		while (valid_sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 8);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 10)
					degree = ($urandom_range(0, 1) == 0) ? 5'd0 : DEGREE_W'($urandom_range(17, 31));
				else if (pick < 75)
					degree = DEGREE_W'($urandom_range(1, 8));
				else
					degree = DEGREE_W'($urandom_range(9, MAX_DEGREE));
				send_degree(degree);
				if (degree != 0 && degree <= MAX_DEGREE)
					valid_sent++;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
			if ($urandom_range(0, 24) == 0) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (pending_terms.size() != 0)
					@(posedge clk);
			end else if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_terms.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("binomial_derivative_product_core test passed");
		else
			$display("binomial_derivative_product_core test failed");
		$finish;
	end

	always @(posedge clk) begin
		if (sink_phase_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_phase_left = $urandom_range(16, 96);
		end
		sink_phase_left--;
		case (sink_mode)
			SINK_OPEN: begin
				m_axis_tready <= 1'b1;
			end
			SINK_CHOPPY: begin
				m_axis_tready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				m_axis_tready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	always @(posedge clk) begin
		product_term_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_terms.size() == 0) begin
				$error("unexpected output transfer: coefficient %0d, power_index %0d",
					m_axis_tdata[COEF_W-1:0], m_axis_tdata[COEF_W+POWER_W-1:COEF_W]);
				fail_count++;
			end else begin
				want = pending_terms.pop_front();
				if (m_axis_tdata[COEF_W-1:0] !== want.coefficient) begin
					$error("coefficient mismatch: expected %0d, actual %0d",
						want.coefficient, m_axis_tdata[COEF_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[COEF_W+POWER_W-1:COEF_W] !== want.power_index) begin
					$error("power_index mismatch: expected %0d, actual %0d",
						want.power_index, m_axis_tdata[COEF_W+POWER_W-1:COEF_W]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("binomial_derivative_product_core test failed");
			$finish;
		end
	end

endmodule
